// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ILP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ILP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/ilp_pkg.sv -----
// ----------------------------------------------------------------------------
// ilp_pkg
// Types, character codes and digit decode for the integer literal parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ilp_pkg;

  localparam int unsigned COUNT_W     = 8;
  localparam int unsigned OUT_VALUE_W = 64;
  localparam int unsigned CFG_IDX_W   = 4;
  localparam int unsigned CFG_DATA_W  = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // ASCII codes
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LB    = 8'h62;
  localparam logic [7:0] CH_UB    = 8'h42;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_MINUS = 8'h2d;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PARSE_MODE  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_SELECT = 4'd1;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_ZERO   = 2'd1,
    PH_NEED   = 2'd2,
    PH_DIGITS = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    BASE_BIN = 2'd0,
    BASE_OCT = 2'd1,
    BASE_DEC = 2'd2,
    BASE_HEX = 2'd3
  } base_t;

  typedef struct packed {
    phase_t             phase;
    logic               neg;
    base_t              base;
    logic [COUNT_W-1:0] cnt;
    logic               mode;   // mode latched at the start of the literal
  } ilp_state_t;

  localparam ilp_state_t STATE_RESET = '{
    phase: PH_IDLE, neg: 1'b0, base: BASE_DEC, cnt: '0, mode: 1'b0
  };

  typedef struct packed {
    logic               emit;
    logic               ok;
    logic [COUNT_W-1:0] consumed;
  } ilp_result_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] val;
  } digit_t;

  // Digit value of c, hit only if it is a legal digit of base b.
  function automatic digit_t digit_decode(input logic [7:0] c, input base_t b);
    digit_t     r;
    logic [7:0] t;
    r.hit = 1'b0;
    t     = '0;
    if (c >= CH_0 && c <= CH_9) begin
      t     = c - CH_0;
      r.hit = 1'b1;
    end else if (c >= CH_LA && c <= CH_LF) begin
      t     = c - CH_LA + 8'd10;
      r.hit = 1'b1;
    end else if (c >= CH_UA && c <= CH_UF) begin
      t     = c - CH_UA + 8'd10;
      r.hit = 1'b1;
    end
    r.val = t[3:0];
    case (b)
      BASE_BIN: if (t[3:1] != 3'd0) r.hit = 1'b0;
      BASE_OCT: if (t[3]) r.hit = 1'b0;
      BASE_DEC: if (t[3:0] > 4'd9) r.hit = 1'b0;
      default:  ;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ilp_step.sv -----
// ----------------------------------------------------------------------------
// ilp_step
// Per-character parse step: next phase, accumulator update and result.
// ----------------------------------------------------------------------------
`default_nettype none

module ilp_step
  import ilp_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic [7:0]             ch,
  input  logic                   first,
  input  logic                   line_end,
  input  logic                   parse_mode,
  input  base_t                  base_select,
  input  ilp_state_t             cur_state,
  input  logic [VALUE_WIDTH-1:0] acc,
  output ilp_state_t             state_nxt,
  output logic [VALUE_WIDTH-1:0] acc_nxt,
  output ilp_result_t            result
);

  logic                   start_zero;
  logic                   start_minus;
  logic                   is_prefix;
  logic                   zero_fall;
  logic                   mode_eff;
  logic                   neg_eff;
  phase_t                 work_phase;
  phase_t                 proc_phase;
  phase_t                 phase_nxt;
  base_t                  base_eff;
  base_t                  base_nxt;
  logic                   neg_nxt;
  logic [COUNT_W-1:0]     cnt_eff;
  logic [COUNT_W-1:0]     cnt_inc;
  logic [COUNT_W-1:0]     cnt_nxt;
  logic [VALUE_WIDTH-1:0] acc_eff;
  logic [VALUE_WIDTH-1:0] dz;
  logic [VALUE_WIDTH-1:0] scaled;
  digit_t                 dig;

  assign start_zero  = first && !parse_mode && (ch == CH_0);
  assign start_minus = first && parse_mode && (ch == CH_MINUS);
  assign work_phase  = first ? PH_NEED : cur_state.phase;
  assign is_prefix   = (work_phase == PH_ZERO) &&
                       (ch == CH_LB || ch == CH_UB || ch == CH_LX || ch == CH_UX);
  // bare leading zero: it was the first octal digit
  assign zero_fall   = (work_phase == PH_ZERO) && !is_prefix;
  assign proc_phase  = zero_fall ? PH_DIGITS : work_phase;

  assign mode_eff = first ? parse_mode : cur_state.mode;
  assign neg_eff  = first ? 1'b0 : cur_state.neg;
  assign cnt_eff  = first ? '0 : cur_state.cnt;
  assign acc_eff  = (first || zero_fall) ? '0 : acc;

  always_comb begin
    if (first) begin
      base_eff = parse_mode ? base_select : BASE_DEC;
    end else if (zero_fall) begin
      base_eff = BASE_OCT;
    end else begin
      base_eff = cur_state.base;
    end
  end

  assign dig     = digit_decode(ch, base_eff);
  assign dz      = VALUE_WIDTH'(dig.val);
  assign cnt_inc = (cnt_eff == COUNT_MAX) ? cnt_eff : cnt_eff + 1'b1;

  // acc * base, by shifts and, for decimal, one add
  always_comb begin
    case (base_eff)
      BASE_BIN: scaled = acc_eff << 1;
      BASE_OCT: scaled = acc_eff << 3;
      BASE_DEC: scaled = (acc_eff << 3) + (acc_eff << 1);
      default:  scaled = acc_eff << 4;
    endcase
  end

  // next phase
  always_comb begin
    phase_nxt = cur_state.phase;
    if (start_zero) begin
      phase_nxt = line_end ? PH_IDLE : PH_ZERO;
    end else if (start_minus || is_prefix) begin
      phase_nxt = line_end ? PH_IDLE : PH_NEED;
    end else begin
      unique case (proc_phase) inside
        PH_NEED, PH_DIGITS: phase_nxt = (!dig.hit || line_end) ? PH_IDLE : PH_DIGITS;
        default:            phase_nxt = PH_IDLE;
      endcase
    end
  end

  // datapath and result; a negative literal accumulates negated
  always_comb begin
    acc_nxt         = acc_eff;
    neg_nxt         = neg_eff;
    base_nxt        = base_eff;
    cnt_nxt         = cnt_eff;
    result.emit     = 1'b0;
    result.ok       = 1'b0;
    result.consumed = '0;
    if (start_zero) begin
      cnt_nxt         = COUNT_W'(1);
      result.emit     = line_end;
      result.ok       = 1'b1;
      result.consumed = COUNT_W'(1);
    end else if (start_minus) begin
      neg_nxt     = 1'b1;
      cnt_nxt     = COUNT_W'(1);
      result.emit = line_end;
    end else if (is_prefix) begin
      base_nxt        = (ch == CH_LB || ch == CH_UB) ? BASE_BIN : BASE_HEX;
      cnt_nxt         = COUNT_W'(2);
      result.emit     = line_end;
      result.consumed = mode_eff ? '0 : COUNT_W'(2);
    end else begin
      unique case (proc_phase)
        PH_NEED: begin
          if (dig.hit) begin
            acc_nxt         = neg_eff ? ('0 - dz) : dz;
            cnt_nxt         = cnt_inc;
            result.emit     = line_end;
            result.ok       = 1'b1;
            result.consumed = cnt_inc;
          end else begin
            result.emit     = 1'b1;
            result.consumed = mode_eff ? '0 : cnt_eff;
          end
        end
        PH_DIGITS: begin
          if (dig.hit) begin
            acc_nxt         = neg_eff ? (scaled - dz) : (scaled + dz);
            cnt_nxt         = cnt_inc;
            result.emit     = line_end;
            result.ok       = 1'b1;
            result.consumed = cnt_inc;
          end else begin
            result.emit     = 1'b1;
            result.ok       = 1'b1;
            result.consumed = cnt_eff;
          end
        end
        default: ;
      endcase
    end
  end

  assign state_nxt = '{phase: phase_nxt, neg: neg_nxt, base: base_nxt,
                       cnt: cnt_nxt, mode: mode_eff};

endmodule

`default_nettype wire

// ----- rtl/core/integer_literal_parser_core.sv -----
// ----------------------------------------------------------------------------
// integer_literal_parser_core
// Streams ASCII characters in, one integer literal result per parse out.
//
// Input channel (in_*): one character per beat, with first marking the start
// of a literal and line_end marking the last character of the line.
// Result channel (out_*): ok, the value (sign-extended from VALUE_WIDTH to
// 64 bits, zero on failure) and the count of characters consumed.
// Config channel (cfg_*): index 0 = parse mode, 1 = explicit base; always
// ready, write only while no parse is in flight. Mode is latched per literal.
//
// Timing: beat is captured in an input register, stepped through the parse
// logic and its result lands in the output register as the beat advances.
// One beat per cycle is sustained while the output slot is free or draining;
// the per-character multiply-add (shift-and-add by the base) sits between
// the input register and the parse state registers.
// Stall: when out_stall holds a pending result, the input register holds
// its beat and in_stall is raised until the output slot frees.
// Reset (rst_n low, synchronous): both channels empty, parser idle,
// parse mode 0, base select decimal.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module integer_literal_parser_core
  import ilp_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input characters
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_ch,
  input  logic                          in_first,
  input  logic                          in_line_end,
  // results
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_ok,
  output logic signed [OUT_VALUE_W-1:0] out_value,
  output logic [COUNT_W-1:0]            out_consumed,
  // configuration writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_wdata
);

  // configuration
  logic                          parse_mode_r;
  base_t                         base_select_r;

  // input register
  logic                          s1_valid_r;
  logic [7:0]                    s1_ch_r;
  logic                          s1_first_r;
  logic                          s1_line_end_r;

  // parse state
  ilp_state_t                    state_r;
  logic [VALUE_WIDTH-1:0]        acc_r;

  // output register
  logic                          out_valid_r;
  logic                          out_ok_r;
  logic signed [OUT_VALUE_W-1:0] out_value_r;
  logic [COUNT_W-1:0]            out_consumed_r;

  logic                          advance;
  logic                          in_take;
  ilp_state_t                    step_state;
  logic [VALUE_WIDTH-1:0]        step_acc;
  logic signed [VALUE_WIDTH-1:0] step_acc_s;
  ilp_result_t                   step_res;
  logic signed [OUT_VALUE_W-1:0] out_value_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      parse_mode_r  <= 1'b0;
      base_select_r <= BASE_DEC;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PARSE_MODE:  parse_mode_r  <= cfg_wdata[0];
        REG_BASE_SELECT: base_select_r <= base_t'(cfg_wdata);
        default:         ;
      endcase
    end
  end

  // The held character steps once the output slot is free or draining.
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_ch_r       <= in_ch;
      s1_first_r    <= in_first;
      s1_line_end_r <= in_line_end;
    end
  end

  ilp_step #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_step (
    .ch          (s1_ch_r),
    .first       (s1_first_r),
    .line_end    (s1_line_end_r),
    .parse_mode  (parse_mode_r),
    .base_select (base_select_r),
    .cur_state   (state_r),
    .acc         (acc_r),
    .state_nxt   (step_state),
    .acc_nxt     (step_acc),
    .result      (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_RESET;
      acc_r   <= '0;
    end else if (advance) begin
      state_r <= step_state;
      acc_r   <= step_acc;
    end
  end

  // value wraps at VALUE_WIDTH, then sign-extends to the port width
  assign step_acc_s    = step_acc;
  assign out_value_nxt = step_res.ok ? OUT_VALUE_W'(step_acc_s) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && step_res.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step_res.emit) begin
      out_ok_r       <= step_res.ok;
      out_value_r    <= out_value_nxt;
      out_consumed_r <= step_res.consumed;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_ok       = out_ok_r;
  assign out_value    = out_value_r;
  assign out_consumed = out_consumed_r;

  // a held character is never dropped
  `ILP_ASSERT_NXT(a_s1_hold, s1_valid_r && !advance, s1_valid_r, "held beat lost")
  // a pending result is never overwritten
  `ILP_ASSERT_IMP(a_no_overrun, advance && out_valid_r, !out_stall, "result overrun")
  // failed parse carries a zero value
  `ILP_ASSERT_IMP(a_fail_zero, out_valid_r && !out_ok_r, out_value_r == '0, "fail value")
  // a good literal consumed at least one character
  `ILP_ASSERT_IMP(a_ok_count, out_valid_r && out_ok_r, out_consumed_r != '0, "ok count")

endmodule

`default_nettype wire

// ----- sim/integer_literal_parser_chk.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// integer_literal_parser_chk
// Watches the character, result and register channels of the parser core.
// Keeps its own model of the parse for each accepted character, queues the
// literal it should produce and compares each result beat against it.
// ----------------------------------------------------------------------------
module integer_literal_parser_chk
  import ilp_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [7:0]                    in_ch,
  input  logic                          in_first,
  input  logic                          in_line_end,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic                          out_ok,
  input  logic signed [OUT_VALUE_W-1:0] out_value,
  input  logic [COUNT_W-1:0]            out_consumed,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_wdata,
  output int unsigned                   mismatches,
  output int unsigned                   results_owed
);

  localparam logic [63:0] VALUE_MASK =
    (VALUE_WIDTH >= 64) ? '1 : ((64'd1 << VALUE_WIDTH) - 64'd1);

  typedef struct packed {
    logic               ok;
    logic [63:0]        value;
    logic [COUNT_W-1:0] consumed;
  } literal_t;

  literal_t literal_q[$];

  // register copies and parse state
  logic               reg_mode;
  base_t              reg_base;
  phase_t             ph;
  base_t              lit_base;
  logic               lit_mode;
  logic               neg;
  logic [63:0]        acc;
  logic [COUNT_W-1:0] cnt;

  function automatic logic [63:0] radix_of(input base_t b);
    case (b)
      BASE_BIN: return 64'd2;
      BASE_OCT: return 64'd8;
      BASE_DEC: return 64'd10;
      default:  return 64'd16;
    endcase
  endfunction

  function automatic logic digit_in_base(input logic [7:0] c, input base_t b,
                                         output logic [3:0] d);
    logic [7:0] v;
    logic       hit;
    hit = 1'b1;
    v   = '0;
    if (c >= CH_0 && c <= CH_9) v = c - CH_0;
    else if (c >= CH_LA && c <= CH_LF) v = c - CH_LA + 8'd10;
    else if (c >= CH_UA && c <= CH_UF) v = c - CH_UA + 8'd10;
    else hit = 1'b0;
    if (64'(v) >= radix_of(b)) hit = 1'b0;
    d = v[3:0];
    return hit;
  endfunction

  task automatic close_ok();
    logic [63:0] v;
    v = (neg ? (64'd0 - acc) : acc) & VALUE_MASK;
    if (v[VALUE_WIDTH-1]) v = v | ~VALUE_MASK;
    literal_q.push_back('{ok: 1'b1, value: v, consumed: cnt});
    ph = PH_IDLE;
  endtask

  // a failed prefix literal still reports the prefix it took
  task automatic close_fail();
    literal_q.push_back('{ok: 1'b0, value: 64'd0, consumed: lit_mode ? '0 : cnt});
    ph = PH_IDLE;
  endtask

  task automatic count_char();
    if (cnt != COUNT_MAX) cnt = cnt + 1'b1;
  endtask

  task automatic step_parser(input logic [7:0] c, input logic first, input logic last);
    logic [3:0] d;
    if (first) begin
      acc      = '0;
      neg      = 1'b0;
      cnt      = '0;
      lit_mode = reg_mode;
      if (!lit_mode) begin
        lit_base = BASE_DEC;
        if (c == CH_0) begin
          cnt = COUNT_W'(1);
          ph  = PH_ZERO;
          if (last) close_ok();
          return;
        end
      end else begin
        lit_base = reg_base;
        if (c == CH_MINUS) begin
          neg = 1'b1;
          cnt = COUNT_W'(1);
          ph  = PH_NEED;
          if (last) close_fail();
          return;
        end
      end
      ph = PH_NEED;
    end
    if (ph == PH_IDLE) return;
    if (ph == PH_ZERO) begin
      if (c == CH_LB || c == CH_UB || c == CH_LX || c == CH_UX) begin
        lit_base = (c == CH_LB || c == CH_UB) ? BASE_BIN : BASE_HEX;
        cnt      = COUNT_W'(2);
        ph       = PH_NEED;
        if (last) close_fail();
        return;
      end
      // bare leading zero: it is the first octal digit
      lit_base = BASE_OCT;
      acc      = '0;
      ph       = PH_DIGITS;
    end
    if (ph == PH_NEED) begin
      if (!digit_in_base(c, lit_base, d)) begin
        close_fail();
        return;
      end
      acc = 64'(d);
      count_char();
      ph = PH_DIGITS;
      if (last) close_ok();
      return;
    end
    if (!digit_in_base(c, lit_base, d)) begin
      close_ok();
      return;
    end
    acc = (acc * radix_of(lit_base) + 64'(d)) & VALUE_MASK;
    count_char();
    if (last) close_ok();
  endtask

  always @(posedge clk) begin : watch
    literal_t want;
    if (!rst_n) begin
      literal_q.delete();
      reg_mode   = 1'b0;
      reg_base   = BASE_DEC;
      ph         = PH_IDLE;
      lit_base   = BASE_DEC;
      lit_mode   = 1'b0;
      neg        = 1'b0;
      acc        = '0;
      cnt        = '0;
      mismatches = 0;
    end else begin
      // result first: a result at this edge comes from an earlier beat
      if (out_valid && !out_stall) begin
        if (literal_q.size() == 0) begin
          $display("%0t: result with none expected: ok %0b value %0d consumed %0d",
                   $time, out_ok, out_value, out_consumed);
          mismatches++;
        end else begin
          want = literal_q.pop_front();
          if (out_ok !== want.ok) begin
            $display("%0t: ok expected %0b actual %0b", $time, want.ok, out_ok);
            mismatches++;
          end
          if (out_value !== want.value) begin
            $display("%0t: value expected %0d actual %0d", $time,
                     $signed(want.value), out_value);
            mismatches++;
          end
          if (out_consumed !== want.consumed) begin
            $display("%0t: consumed expected %0d actual %0d", $time,
                     want.consumed, out_consumed);
            mismatches++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_PARSE_MODE) reg_mode = cfg_wdata[0];
        else if (cfg_index == REG_BASE_SELECT) reg_base = base_t'(cfg_wdata);
      end
      if (in_valid && !in_stall) step_parser(in_ch, in_first, in_line_end);
    end
    results_owed = literal_q.size();
  end

endmodule

// ----- sim/integer_literal_parser_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// integer_literal_parser_core_tb
// Feeds character streams into the parser core: a directed run through the
// prefix, sign, failure and abandon cases, then phases of random literals
// under changing register settings with random idles and result stalls.
// A checker beside the core predicts and compares every result.
// ----------------------------------------------------------------------------
module integer_literal_parser_core_tb;
  import ilp_pkg::*;

  localparam int unsigned VALUE_WIDTH    = 64;
  localparam int unsigned WATCHDOG_LIMIT = 2000;  // cycles without any beat
  localparam int          ITEM_TARGET    = 400;

  logic                          clk;
  logic                          rst_n       = 1'b0;
  logic                          in_valid    = 1'b0;
  logic                          in_stall;
  logic [7:0]                    in_ch       = '0;
  logic                          in_first    = 1'b0;
  logic                          in_line_end = 1'b0;
  logic                          out_valid;
  logic                          out_stall   = 1'b0;
  logic                          out_ok;
  logic signed [OUT_VALUE_W-1:0] out_value;
  logic [COUNT_W-1:0]            out_consumed;
  logic                          cfg_valid   = 1'b0;
  logic                          cfg_ready;
  logic [CFG_IDX_W-1:0]          cfg_index   = '0;
  logic [CFG_DATA_W-1:0]         cfg_wdata   = '0;

  int unsigned mismatches;
  int unsigned results_owed;
  int unsigned quiet_cycles = 0;
  // every character beat taken by the core
  int          items_sent   = 0;

  // steady = no idling on either side (the long burst stretch)
  logic  steady = 1'b0;
  // settings as last written, used to shape well-formed literals
  logic  cur_mode = 1'b0;
  base_t cur_base = BASE_DEC;

  integer_literal_parser_core #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_ch        (in_ch),
    .in_first     (in_first),
    .in_line_end  (in_line_end),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_ok       (out_ok),
    .out_value    (out_value),
    .out_consumed (out_consumed),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  integer_literal_parser_chk #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_ch        (in_ch),
    .in_first     (in_first),
    .in_line_end  (in_line_end),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_ok       (out_ok),
    .out_value    (out_value),
    .out_consumed (out_consumed),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .mismatches   (mismatches),
    .results_owed (results_owed)
  );

  // 20 ns clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // result side: stall about 7 beats in 100, never during the steady stretch
  always @(negedge clk) begin
    out_stall <= rst_n && !steady && ($urandom_range(99, 0) < 7);
  end

  // watchdog: any accepted beat on any channel restarts the count
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL integer_literal_parser_core");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One character beat. Called right after the previous beat was taken, so
  // the first negedge here is the only chance to drop valid for an idle gap.
  task automatic send_char(input logic [7:0] c, input logic first, input logic last);
    @(negedge clk);
    while (!steady && $urandom_range(99, 0) < 7) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_ch       <= c;
    in_first    <= first;
    in_line_end <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Send a string; the first flag applies to its first character and the
  // line end, if asked, to its last.
  task automatic send_text(input string s, input logic first, input logic end_line);
    for (int i = 0; i < s.len(); i++)
      send_char(s[i], first && (i == 0), end_line && (i == s.len() - 1));
  endtask

  // Stop sending and hold off until every predicted result has come back,
  // then keep waiting for a beat still inside the core's pipeline.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(input logic mode, input base_t b);
    write_reg(REG_PARSE_MODE, {1'b0, mode});
    write_reg(REG_BASE_SELECT, b);
    cur_mode = mode;
    cur_base = b;
  endtask

  function automatic int digit_limit(input base_t b);
    case (b)
      BASE_BIN: return 2;
      BASE_OCT: return 8;
      BASE_DEC: return 10;
      default:  return 16;
    endcase
  endfunction

  // ASCII for a digit value, letters in random case
  function automatic logic [7:0] digit_char(input int v);
    if (v < 10) return CH_0 + 8'(v);
    return ($urandom_range(1, 0) ? CH_LA : CH_UA) + 8'(v - 10);
  endfunction

  // A mostly well-formed literal for the current settings: prefix or sign,
  // digits of the base, then a line end, a random trailing byte or nothing (the
  // next literal's first character then abandons it). Now and then one byte
  // is overwritten with garbage. forced > 0 fixes the digit count.
  task automatic send_literal(input int forced, output int n);
    logic [7:0] text[$];
    base_t      b;
    int         ndig;
    int         tail;
    logic       last;
    b = cur_base;
    if (!cur_mode) begin
      case ($urandom_range(3, 0))
        0: begin
          b = BASE_DEC;
          text.push_back(digit_char($urandom_range(9, 1)));
        end
        1: begin
          b = BASE_HEX;
          text.push_back(CH_0);
          text.push_back($urandom_range(1, 0) ? CH_LX : CH_UX);
        end
        2: begin
          b = BASE_BIN;
          text.push_back(CH_0);
          text.push_back($urandom_range(1, 0) ? CH_LB : CH_UB);
        end
        default: begin
          b = BASE_OCT;
          text.push_back(CH_0);
        end
      endcase
    end else if ($urandom_range(1, 0)) begin
      text.push_back(CH_MINUS);
    end
    if (forced > 0) ndig = forced;
    else if ($urandom_range(9, 0) == 0) ndig = $urandom_range(70, 17);  // long, may wrap
    else ndig = $urandom_range(6, 0);
    repeat (ndig) text.push_back(digit_char($urandom_range(digit_limit(b) - 1, 0)));
    tail = $urandom_range(7, 0);
    if (tail >= 4 && tail < 7) text.push_back(8'($urandom_range(255, 0)));
    if (text.size() == 0) text.push_back(8'($urandom_range(255, 0)));
    if ($urandom_range(19, 0) == 0)
      text[$urandom_range(text.size() - 1, 0)] = 8'($urandom_range(255, 0));
    foreach (text[i]) begin
      last = (i == text.size() - 1) && (tail < 4 || (tail < 7 && $urandom_range(1, 0)));
      send_char(text[i], i == 0, last);
    end
    n = text.size();
  endtask

  initial begin : stimulus
    int phase_no;
    int phase_start;
    int phase_goal;
    int n;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // --- directed: prefix mode out of reset ---
    send_text("0", 1'b1, 1'b1);           // lone zero
    send_text("0xfF,", 1'b1, 1'b0);       // hex, ended by a non-digit
    send_char(8'hFF, 1'b0, 1'b0);         // idle character, no result
    send_text("0b", 1'b1, 1'b1);          // prefix only: fail, prefix counted
    send_text("0X", 1'b1, 1'b0);          // abandoned by the next first
    send_text("7", 1'b1, 1'b1);
    send_text("078", 1'b1, 1'b1);         // octal, stops at the 8
    send_text("-5", 1'b1, 1'b0);          // no sign in prefix mode
    send_text("0x", 1'b1, 1'b0);          // left open across a mode write
    drain();
    set_config(1'b1, BASE_DEC);
    send_text("g", 1'b0, 1'b1);           // fails under the latched prefix mode

    // --- directed: explicit mode ---
    drain();
    set_config(1'b1, BASE_HEX);
    send_text("-aB", 1'b1, 1'b1);
    send_text("-", 1'b1, 1'b1);           // sign alone
    send_char(8'h00, 1'b1, 1'b1);
    drain();
    set_config(1'b1, BASE_BIN);
    send_text("-1012", 1'b1, 1'b1);

    // --- random phases, each under its own register setting ---
    phase_no = 0;
    while (items_sent < ITEM_TARGET) begin
      drain();  // every result in before the next register write
      case (phase_no)
        0:       set_config(1'b0, BASE_DEC);
        1:       set_config(1'b1, BASE_BIN);
        2:       set_config(1'b1, BASE_HEX);
        default: set_config(1'($urandom_range(1, 0)), base_t'($urandom_range(3, 0)));
      endcase
      steady      = (phase_no == 1);
      phase_goal  = steady ? 80 : 30;
      phase_start = items_sent;
      // one literal long enough to saturate the consumed count
      if (phase_no == 2) send_literal(258, n);
      while (items_sent - phase_start < phase_goal) begin
        if ($urandom_range(99, 0) < 15) begin
          repeat ($urandom_range(4, 1))
            send_char(8'($urandom_range(255, 0)), $urandom_range(3, 0) == 0,
                      $urandom_range(3, 0) == 0);
        end else begin
          send_literal(0, n);
        end
      end
      phase_no++;
    end

    steady = 1'b0;
    drain();
    repeat (8) @(negedge clk);
    if (mismatches == 0 && results_owed == 0) begin
      $display("PASS integer_literal_parser_core");
    end else begin
      $display("FAIL integer_literal_parser_core");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/ilp_pkg.sv
rtl/core/ilp_step.sv
rtl/core/integer_literal_parser_core.sv
sim/integer_literal_parser_chk.sv
sim/integer_literal_parser_core_tb.sv
